@@ hdl/rpsb_pkg.sv @@
// rpsb_pkg: shared types and codes for the regex position set builder
// used by every module in hdl/, depends on nothing
package rpsb_pkg;

  localparam int unsigned MaxNodes = 32;
  // store depth is fixed by the 32 bit set masks
  localparam int unsigned NodeCap  = (MaxNodes < 32) ? MaxNodes : 32;
  localparam int unsigned SetW     = 32;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned CntW     = 6;

  // node type codes
  localparam logic [2:0] TypeEnd    = 3'd0;
  localparam logic [2:0] TypeLeaf   = 3'd1;
  localparam logic [2:0] TypeAlt    = 3'd2;
  localparam logic [2:0] TypeConcat = 3'd3;
  localparam logic [2:0] TypeStar   = 3'd4;
  localparam logic [2:0] TypeOpt    = 3'd5;
  localparam logic [2:0] TypePlus   = 3'd6;
  localparam logic [2:0] TypeBad    = 3'd7;

  // result kind codes
  localparam logic [1:0] KindNode   = 2'd0;
  localparam logic [1:0] KindFollow = 2'd1;
  localparam logic [1:0] KindError  = 2'd2;

  typedef struct packed {
    logic            nul;
    logic [SetW-1:0] first;
    logic [SetW-1:0] last;
  } node_rec_t;

  // follow update: every row whose bit is set in rows gains add
  typedef struct packed {
    logic            en;
    logic [SetW-1:0] rows;
    logic [SetW-1:0] add;
  } follow_upd_t;

endpackage

@@ hdl/rpsb_node_store.sv @@
// rpsb_node_store: per-node nullable/first/last memory, two registered reads
// write-through on a same-edge write; depends on rpsb_pkg
module rpsb_node_store
  import rpsb_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  node_rec_t       wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_l_i,
  input  logic [IdxW-1:0] raddr_r_i,
  output node_rec_t       rdata_l_o,
  output node_rec_t       rdata_r_o
);

  node_rec_t mem_q [NodeCap];
  node_rec_t rd_l_q;
  node_rec_t rd_r_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // a child written at the same edge comes straight from the write data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_l_q <= (we_i && waddr_i == raddr_l_i) ? wdata_i : mem_q[raddr_l_i];
      rd_r_q <= (we_i && waddr_i == raddr_r_i) ? wdata_i : mem_q[raddr_r_i];
    end
  end

  assign rdata_l_o = rd_l_q;
  assign rdata_r_o = rd_r_q;

endmodule

@@ hdl/rpsb_node_eval.sv @@
// rpsb_node_eval: checks one node and derives its sets and follow update
// purely combinational; depends on rpsb_pkg
module rpsb_node_eval
  import rpsb_pkg::*;
(
  input  logic [2:0]      node_type_i,
  input  logic [IdxW-1:0] left_i,
  input  logic [IdxW-1:0] right_i,
  input  logic [CntW-1:0] count_i,
  input  node_rec_t       rec_l_i,
  input  node_rec_t       rec_r_i,
  output logic            err_o,
  output node_rec_t       rec_o,
  output follow_upd_t     upd_o
);

  logic l_bad;
  logic r_bad;
  logic own_full;

  assign l_bad    = {1'b0, left_i} >= count_i;
  assign r_bad    = {1'b0, right_i} >= count_i;
  assign own_full = count_i >= CntW'(NodeCap);

  always_comb begin
    err_o = own_full;
    case (node_type_i)
      TypeEnd, TypeLeaf:          err_o = own_full;
      TypeAlt, TypeConcat:        err_o = own_full | l_bad | r_bad;
      TypeStar, TypeOpt, TypePlus: err_o = own_full | l_bad;
      TypeBad:                    err_o = 1'b1;
      default:                    err_o = 1'b1;
    endcase
  end

  always_comb begin
    rec_o    = '0;
    upd_o    = '0;
    case (node_type_i)
      TypeEnd, TypeLeaf: begin
        rec_o.first = SetW'(1) << count_i[IdxW-1:0];
        rec_o.last  = SetW'(1) << count_i[IdxW-1:0];
      end
      TypeAlt: begin
        rec_o.nul   = rec_l_i.nul | rec_r_i.nul;
        rec_o.first = rec_l_i.first | rec_r_i.first;
        rec_o.last  = rec_l_i.last | rec_r_i.last;
      end
      TypeConcat: begin
        rec_o.nul   = rec_l_i.nul & rec_r_i.nul;
        rec_o.first = rec_l_i.first | (rec_l_i.nul ? rec_r_i.first : '0);
        rec_o.last  = rec_r_i.last | (rec_r_i.nul ? rec_l_i.last : '0);
        upd_o.en    = 1'b1;
        upd_o.rows  = rec_l_i.last;
        upd_o.add   = rec_r_i.first;
      end
      TypeStar, TypePlus: begin
        rec_o.nul   = (node_type_i == TypeStar) | rec_l_i.nul;
        rec_o.first = rec_l_i.first;
        rec_o.last  = rec_l_i.last;
        upd_o.en    = 1'b1;
        upd_o.rows  = rec_l_i.last;
        upd_o.add   = rec_l_i.first;
      end
      TypeOpt: begin
        rec_o.nul   = 1'b1;
        rec_o.first = rec_l_i.first;
        rec_o.last  = rec_l_i.last;
      end
      default: begin
        rec_o = '0;
      end
    endcase
  end

endmodule

@@ hdl/rpsb_follow_table.sv @@
// rpsb_follow_table: follow rows in flops, parallel or-update, row readout
// cleared at the end of a readout and at reset; depends on rpsb_pkg
module rpsb_follow_table
  import rpsb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  follow_upd_t     upd_i,
  input  logic            clear_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output logic [SetW-1:0] rd_row_o
);

  logic [SetW-1:0] row_q [NodeCap];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NodeCap; p++) row_q[p] <= '0;
    end else if (clear_i) begin
      for (int p = 0; p < NodeCap; p++) row_q[p] <= '0;
    end else if (upd_i.en) begin
      for (int p = 0; p < NodeCap; p++) begin
        if (upd_i.rows[p]) row_q[p] <= row_q[p] | upd_i.add;
      end
    end
  end

  assign rd_row_o = row_q[rd_idx_i];

endmodule

@@ hdl/regex_position_set_builder.sv @@
// regex_position_set_builder: top level, handshakes, node stage, readout
// depends on rpsb_pkg, rpsb_node_store, rpsb_node_eval, rpsb_follow_table
//
// usage
//   slave channel: one syntax tree node per item, in post-order. tuser holds
//   the node type, tdata the two child indices, tlast marks the root.
//   the node index is implied by arrival order since the last root.
//   master channel: tuser is the result kind (node record, follow row,
//   error), tdata carries index, nullable flag and the three masks, tlast
//   flags the last result caused by an input item.
// flow and throughput
//   when a node item is accepted, its child records are read into the node
//   stage at that edge, and its record then moves to the output register
//   once that register is free. nodes stream at one item per cycle while
//   the receiver keeps up and no readout runs; a child produced by the node
//   just ahead is forwarded from the store write data.
//   a root node is followed by a readout of one follow row per node of the
//   tree, one per cycle while the receiver keeps up, paced by the single
//   follow table read port; no node is accepted until the last row is loaded.
// reset and stall
//   reset empties both stages, zeroes the node count and the follow rows.
//   when the receiver stalls, the result waits in the output register while
//   one more node is held in the node stage, then tready drops.
module regex_position_set_builder
  import rpsb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave side
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [15:0]  s_axis_tdata_i,   // [4:0] left_child, [9:5] right_child, rest zero
  input  logic [2:0]   s_axis_tuser_i,   // [2:0] node_type
  input  logic         s_axis_tlast_i,   // final_node
  // master side
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [4:0] index, [5] is_nullable, [37:6] first_mask, [69:38] last_mask,
  // [101:70] follow_mask, [103:102] zero
  output logic [103:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o,   // [1:0] kind
  output logic         m_axis_tlast_o    // end_of_run
);

  // node stage
  logic            s1_vld_q, s1_vld_d;
  logic [2:0]      s1_type_q;
  logic [IdxW-1:0] s1_l_q;
  logic [IdxW-1:0] s1_r_q;
  logic            s1_fin_q;

  // node count and readout sequencer
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ro_q, ro_d;
  logic [IdxW-1:0] ro_idx_q, ro_idx_d;
  logic [IdxW-1:0] ro_last_q, ro_last_d;

  // output register
  logic            m_vld_q, m_vld_d;
  logic [1:0]      m_kind_q;
  logic [IdxW-1:0] m_idx_q;
  logic            m_nul_q;
  logic [SetW-1:0] m_first_q;
  logic [SetW-1:0] m_last_q;
  logic [SetW-1:0] m_follow_q;
  logic            m_eor_q;

  logic            out_free;
  logic            s1_adv;
  logic            accept;
  logic            ro_step;
  logic            ro_done;
  logic            commit;

  node_rec_t       rec_l;
  node_rec_t       rec_r;
  node_rec_t       rec;
  logic            err;
  follow_upd_t     upd_raw;
  follow_upd_t     upd;
  logic [SetW-1:0] follow_row;

  assign out_free = !m_vld_q || m_axis_tready_i;
  assign s1_adv   = s1_vld_q && out_free;
  assign commit   = s1_adv && !err;
  assign ro_step  = ro_q && out_free;
  assign ro_done  = ro_step && (ro_idx_q == ro_last_q);

  // a root in the node stage blocks the next node until readout is over
  assign s_axis_tready_o = !ro_q && !(s1_vld_q && s1_fin_q) && (!s1_vld_q || out_free);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  rpsb_node_store u_store (
    .clk_i     (clk_i),
    .we_i      (commit),
    .waddr_i   (cnt_q[IdxW-1:0]),
    .wdata_i   (rec),
    .re_i      (accept),
    .raddr_l_i (s_axis_tdata_i[4:0]),
    .raddr_r_i (s_axis_tdata_i[9:5]),
    .rdata_l_o (rec_l),
    .rdata_r_o (rec_r)
  );

  rpsb_node_eval u_eval (
    .node_type_i (s1_type_q),
    .left_i      (s1_l_q),
    .right_i     (s1_r_q),
    .count_i     (cnt_q),
    .rec_l_i     (rec_l),
    .rec_r_i     (rec_r),
    .err_o       (err),
    .rec_o       (rec),
    .upd_o       (upd_raw)
  );

  always_comb begin
    upd    = upd_raw;
    upd.en = upd_raw.en && commit;
  end

  rpsb_follow_table u_follow (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .clear_i  (ro_done),
    .rd_idx_i (ro_idx_q),
    .rd_row_o (follow_row)
  );

  // node stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_type_q <= s_axis_tuser_i;
      s1_l_q    <= s_axis_tdata_i[4:0];
      s1_r_q    <= s_axis_tdata_i[9:5];
      s1_fin_q  <= s_axis_tlast_i;
    end
  end

  // control next state
  always_comb begin
    s1_vld_d  = s1_vld_q;
    cnt_d     = cnt_q;
    ro_d      = ro_q;
    ro_idx_d  = ro_idx_q;
    ro_last_d = ro_last_q;
    m_vld_d   = m_vld_q;

    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end

    if (commit) begin
      cnt_d = cnt_q + CntW'(1);
      if (s1_fin_q) begin
        ro_d      = 1'b1;
        ro_idx_d  = '0;
        ro_last_d = cnt_q[IdxW-1:0];
      end
    end

    if (ro_step) begin
      ro_idx_d = ro_idx_q + IdxW'(1);
      if (ro_done) begin
        ro_d  = 1'b0;
        cnt_d = '0;
      end
    end

    if (s1_adv || ro_step) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      cnt_q     <= '0;
      ro_q      <= 1'b0;
      ro_idx_q  <= '0;
      ro_last_q <= '0;
      m_vld_q   <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      cnt_q     <= cnt_d;
      ro_q      <= ro_d;
      ro_idx_q  <= ro_idx_d;
      ro_last_q <= ro_last_d;
      m_vld_q   <= m_vld_d;
    end
  end

  // output payload: node record or error from the node stage, else a follow row
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_idx_q    <= cnt_q[IdxW-1:0];
      m_follow_q <= '0;
      if (err) begin
        m_kind_q  <= KindError;
        m_nul_q   <= 1'b0;
        m_first_q <= '0;
        m_last_q  <= '0;
        m_eor_q   <= 1'b1;
      end else begin
        m_kind_q  <= KindNode;
        m_nul_q   <= rec.nul;
        m_first_q <= rec.first;
        m_last_q  <= rec.last;
        m_eor_q   <= !s1_fin_q;
      end
    end else if (ro_step) begin
      m_kind_q   <= KindFollow;
      m_idx_q    <= ro_idx_q;
      m_nul_q    <= 1'b0;
      m_first_q  <= '0;
      m_last_q   <= '0;
      m_follow_q <= follow_row;
      m_eor_q    <= ro_done;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_eor_q;
  assign m_axis_tdata_o  = {2'b00, m_follow_q, m_last_q, m_first_q, m_nul_q, m_idx_q};

endmodule
